// ===== design/pid_filtered_derivative_antiwindup_unit_defines.svh =====
// assertion macros used by pidfd_datapath
// no dependencies; pulled in with an include by pidfd_datapath, which checks its own logic
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PIDFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pid unit check failed");
`define PIDFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pid unit check failed");
`else
`define PIDFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PIDFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/pidfd_pkg.sv =====
// types, constants and saturation helper for the pid unit
// used by pidfd_ctrl, pidfd_datapath and the top level
package pidfd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 66;
    localparam int OUT_W         = 152;

    localparam logic [30:0] PROP_GAIN_RST   = 31'd55180;
    localparam logic [30:0] INTEG_GAIN_RST  = 31'd31373;
    localparam logic [30:0] DERIV_GAIN_RST  = 31'd22165;
    localparam logic [30:0] FILTER_COEF_RST = 31'd523523;
    localparam logic [26:0] TARGET_MM_RST   = 27'd9830400;
    localparam logic [16:0] SAMPLE_PER_RST  = 17'd6554;
    localparam logic [16:0] CAL_GAIN_RST    = 17'd57488;

    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_FILTER_COEF = 3'd3,
        REG_TARGET_MM   = 3'd4,
        REG_SAMPLE_PER  = 3'd5,
        REG_CAL_GAIN    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAS, ST_KIH, ST_NK, ST_NT, ST_P,
        ST_INT, ST_DER1, ST_DER2, ST_DWB, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_MEAS, OP_KIH, OP_NK, OP_NT, OP_P,
        OP_INT, OP_DER1, OP_DER2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed(PROD_W'(64'sd2147483647))) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -$signed(PROD_W'(64'sd2147483648))) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/pid_filtered_derivative_antiwindup_unit.sv =====
// Distance-loop PID controller with anti-windup integral and filtered derivative.
// Channels: s_ carries one raw distance sample (s_tdata[15:0], millimetres).
// m_ carries one result per sample; m_tdata fields from bit 0 up:
//   drive [23:0], servo_angle [31:24], error_value [63:32], prop_term [95:64],
//   integ_term [119:96], deriv_term [151:120], all but servo_angle fixed point with FRAC_BITS.
// Gains, setpoint, period and calibration are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while no sample is
// in flight, as the block itself does not enforce it. A sample is worked on
// alone by the single 33x33 multiplier, which the sequencer steps through
// eight products plus writeback and the sum before a new sample is taken.
// s_tready is high only while the sequencer is idle; the result register sits
// between the sides, so a new sample is taken while the last result still waits.
// If the receiver stalls, the finished sample holds in the sequencer until the
// result register is taken, and no further sample is accepted meanwhile.
// Reset (aresetn low, synchronous) reloads register defaults, clears the error,
// integral and derivative history and drops any pending result.
module pid_filtered_derivative_antiwindup_unit #(
    parameter int FRAC_BITS = pidfd_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_index,
    input  logic [30:0]                 cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // distance_mm
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // drive, servo_angle, error_value, prop_term, integ_term, deriv_term
    output logic [pidfd_pkg::OUT_W-1:0] m_tdata
);

    pidfd_pkg::cmd_t    cmd;
    pidfd_pkg::status_t status;

    pidfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pidfd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/pidfd_ctrl.sv =====
// sequencer of the pid unit: steps the shared multiplier through one sample
// depends on pidfd_pkg
module pidfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pidfd_pkg::status_t  status,
    output pidfd_pkg::cmd_t     cmd
);

    pidfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pidfd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pidfd_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pidfd_pkg::ST_MEAS;
            end
            pidfd_pkg::ST_MEAS: state_next = pidfd_pkg::ST_KIH;
            pidfd_pkg::ST_KIH:  state_next = pidfd_pkg::ST_NK;
            pidfd_pkg::ST_NK:   state_next = pidfd_pkg::ST_NT;
            pidfd_pkg::ST_NT:   state_next = pidfd_pkg::ST_P;
            pidfd_pkg::ST_P:    state_next = pidfd_pkg::ST_INT;
            pidfd_pkg::ST_INT:  state_next = pidfd_pkg::ST_DER1;
            pidfd_pkg::ST_DER1: state_next = pidfd_pkg::ST_DER2;
            pidfd_pkg::ST_DER2: state_next = pidfd_pkg::ST_DWB;
            pidfd_pkg::ST_DWB:  state_next = pidfd_pkg::ST_DONE;
            pidfd_pkg::ST_DONE: begin
                if (status.out_free) state_next = pidfd_pkg::ST_IDLE;
            end
            default: state_next = pidfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.op      = pidfd_pkg::OP_NONE;
        cmd.load_in = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            pidfd_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            pidfd_pkg::ST_MEAS: cmd.op = pidfd_pkg::OP_MEAS;
            pidfd_pkg::ST_KIH:  cmd.op = pidfd_pkg::OP_KIH;
            pidfd_pkg::ST_NK:   cmd.op = pidfd_pkg::OP_NK;
            pidfd_pkg::ST_NT:   cmd.op = pidfd_pkg::OP_NT;
            pidfd_pkg::ST_P:    cmd.op = pidfd_pkg::OP_P;
            pidfd_pkg::ST_INT:  cmd.op = pidfd_pkg::OP_INT;
            pidfd_pkg::ST_DER1: cmd.op = pidfd_pkg::OP_DER1;
            pidfd_pkg::ST_DER2: cmd.op = pidfd_pkg::OP_DER2;
            pidfd_pkg::ST_DWB:  cmd.op = pidfd_pkg::OP_NONE;
            pidfd_pkg::ST_DONE: cmd.finish = status.out_free;
            default: cmd.op = pidfd_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== design/pidfd_datapath.sv =====
// datapath of the pid unit: configuration registers, shared multiplier,
// term registers, controller state and result register; depends on pidfd_pkg
`include "pid_filtered_derivative_antiwindup_unit_defines.svh"

module pidfd_datapath #(
    parameter int FRAC_BITS = pidfd_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [30:0]                   cfg_wdata,
    input  logic [15:0]                   s_tdata,
    input  pidfd_pkg::cmd_t               cmd,
    output pidfd_pkg::status_t            status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pidfd_pkg::OUT_W-1:0]   m_tdata
);

    localparam int PW = pidfd_pkg::PROD_W;
    localparam logic signed [33:0] LIMIT = 34'sd90 <<< FRAC_BITS;
    localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;

    logic [30:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg, filter_coef_reg;
    logic [26:0] target_mm_reg;
    logic [16:0] sample_period_reg, cal_gain_reg;

    logic [15:0]            dist_reg;
    pidfd_pkg::op_t         op_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [31:0]     err_reg, p_reg, kih_reg, nk_reg, onem_reg;
    logic signed [31:0]     integ_reg, der1_reg, d_reg;
    logic signed [31:0]     prev_err_reg, prev_integ_reg, prev_deriv_reg;
    logic                   out_valid_reg;
    logic [pidfd_pkg::OUT_W-1:0] out_data_reg;

    logic signed [32:0]     mul_a, mul_b;
    logic signed [32:0]     esum, ediff;
    logic signed [PW-1:0]   shifted;
    logic signed [31:0]     mq;
    logic signed [31:0]     err_next, p_next, kih_next, nk_next, onem_next;
    logic signed [31:0]     integ_next, der1_next, d_next, integ_sat;
    logic signed [33:0]     sum, drive, servo_full;
    logic                   out_valid_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= pidfd_pkg::PROP_GAIN_RST;
            integ_gain_reg    <= pidfd_pkg::INTEG_GAIN_RST;
            deriv_gain_reg    <= pidfd_pkg::DERIV_GAIN_RST;
            filter_coef_reg   <= pidfd_pkg::FILTER_COEF_RST;
            target_mm_reg     <= pidfd_pkg::TARGET_MM_RST;
            sample_period_reg <= pidfd_pkg::SAMPLE_PER_RST;
            cal_gain_reg      <= pidfd_pkg::CAL_GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidfd_pkg::REG_PROP_GAIN:   prop_gain_reg     <= cfg_wdata;
                pidfd_pkg::REG_INTEG_GAIN:  integ_gain_reg    <= cfg_wdata;
                pidfd_pkg::REG_DERIV_GAIN:  deriv_gain_reg    <= cfg_wdata;
                pidfd_pkg::REG_FILTER_COEF: filter_coef_reg   <= cfg_wdata;
                pidfd_pkg::REG_TARGET_MM:   target_mm_reg     <= cfg_wdata[26:0];
                pidfd_pkg::REG_SAMPLE_PER:  sample_period_reg <= cfg_wdata[16:0];
                pidfd_pkg::REG_CAL_GAIN:    cal_gain_reg      <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // operand selection
    always_comb begin
        esum  = 33'(err_reg) + 33'(prev_err_reg);
        ediff = 33'(err_reg) - 33'(prev_err_reg);
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pidfd_pkg::OP_MEAS: begin
                mul_a = {17'd0, dist_reg};
                mul_b = {16'd0, cal_gain_reg};
            end
            pidfd_pkg::OP_KIH: begin
                mul_a = {2'd0, integ_gain_reg};
                mul_b = {16'd0, sample_period_reg};
            end
            pidfd_pkg::OP_NK: begin
                mul_a = {2'd0, filter_coef_reg};
                mul_b = {2'd0, deriv_gain_reg};
            end
            pidfd_pkg::OP_NT: begin
                mul_a = {2'd0, filter_coef_reg};
                mul_b = {16'd0, sample_period_reg};
            end
            pidfd_pkg::OP_P: begin
                mul_a = {2'd0, prop_gain_reg};
                mul_b = 33'(err_reg);
            end
            pidfd_pkg::OP_INT: begin
                mul_a = 33'(kih_reg);
                mul_b = 33'(pidfd_pkg::sat32(PW'(esum)));
            end
            pidfd_pkg::OP_DER1: begin
                mul_a = 33'(nk_reg);
                mul_b = 33'(pidfd_pkg::sat32(PW'(ediff)));
            end
            pidfd_pkg::OP_DER2: begin
                mul_a = 33'(onem_reg);
                mul_b = 33'(prev_deriv_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product writeback
    always_comb begin
        case (op_reg)
            pidfd_pkg::OP_MEAS: shifted = prod_reg;
            pidfd_pkg::OP_KIH:  shifted = prod_reg >>> (FRAC_BITS + 1);
            default:            shifted = prod_reg >>> FRAC_BITS;
        endcase
        mq = pidfd_pkg::sat32(shifted);

        err_next   = err_reg;
        p_next     = p_reg;
        kih_next   = kih_reg;
        nk_next    = nk_reg;
        onem_next  = onem_reg;
        integ_next = integ_reg;
        der1_next  = der1_reg;
        d_next     = d_reg;
        integ_sat  = pidfd_pkg::sat32(PW'(mq) + PW'(prev_integ_reg));
        case (op_reg)
            pidfd_pkg::OP_MEAS: err_next = pidfd_pkg::sat32(
                PW'({1'b0, target_mm_reg}) - PW'(mq));
            pidfd_pkg::OP_KIH:  kih_next = mq;
            pidfd_pkg::OP_NK:   nk_next = mq;
            pidfd_pkg::OP_NT:   onem_next = pidfd_pkg::sat32(PW'(ONE_Q) - PW'(mq));
            pidfd_pkg::OP_P:    p_next = mq;
            pidfd_pkg::OP_INT: begin
                if (34'(integ_sat) > LIMIT) begin
                    integ_next = LIMIT[31:0];
                end else if (34'(integ_sat) < -LIMIT) begin
                    integ_next = 32'(-LIMIT);
                end else begin
                    integ_next = integ_sat;
                end
            end
            pidfd_pkg::OP_DER1: der1_next = mq;
            pidfd_pkg::OP_DER2: d_next = pidfd_pkg::sat32(PW'(der1_reg) + PW'(mq));
            default: ;
        endcase
    end

    // final sum, clamp (drive forced to zero when the error is zero) and servo angle
    always_comb begin
        sum = 34'(p_reg) + 34'(integ_reg) + 34'(d_reg);
        if (sum > LIMIT) begin
            drive = LIMIT;
        end else if (sum < -LIMIT) begin
            drive = -LIMIT;
        end else begin
            drive = sum;
        end
        if (err_reg == 32'sd0) drive = '0;
        servo_full = (drive + LIMIT) >>> FRAC_BITS;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg         <= pidfd_pkg::OP_NONE;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            prev_integ_reg <= '0;
            prev_deriv_reg <= '0;
        end else begin
            op_reg        <= cmd.op;
            out_valid_reg <= out_valid_next;
            if (cmd.finish) begin
                prev_err_reg   <= err_reg;
                prev_integ_reg <= integ_reg;
                prev_deriv_reg <= d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) dist_reg <= s_tdata;
        prod_reg  <= mul_a * mul_b;
        err_reg   <= err_next;
        p_reg     <= p_next;
        kih_reg   <= kih_next;
        nk_reg    <= nk_next;
        onem_reg  <= onem_next;
        integ_reg <= integ_next;
        der1_reg  <= der1_next;
        d_reg     <= d_next;
        if (cmd.finish) begin
            out_data_reg <= {d_reg, integ_reg[23:0], p_reg, err_reg,
                             servo_full[7:0], drive[23:0]};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    `PIDFD_ASSERT_IMP(a_finish_slot_free, aclk, aresetn, cmd.finish,
        !(out_valid_reg && !m_tready))
    `PIDFD_ASSERT_NXT(a_drive_in_range, aclk, aresetn, cmd.finish,
        ($signed(m_tdata[23:0]) <= $signed(LIMIT[23:0])) &&
        ($signed(m_tdata[23:0]) >= -$signed(LIMIT[23:0])))
    `PIDFD_ASSERT_NXT(a_zero_error_centre, aclk, aresetn,
        cmd.finish && (err_reg == 32'sd0), m_tdata[31:24] == 8'd90)
    `PIDFD_ASSERT_IMP(a_integ_clamped, aclk, aresetn, 1'b1,
        (34'(prev_integ_reg) <= LIMIT) && (34'(prev_integ_reg) >= -LIMIT))

endmodule
